### src/ptsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptsc_pkg
// Shared types and constants of the pitch track speech classifier core.
// ----------------------------------------------------------------------------
package ptsc_pkg;

    // field widths
    localparam int SRC_W   = 3;
    localparam int LAG_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CAT_W   = 2;

    // default number of tracked sources
    localparam int NUM_SOURCES_DEF = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEECH_THR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd7;

    // register reset values
    localparam logic [CFG_W-1:0] RST_LAG_MIN    = 16'd0;
    localparam logic [CFG_W-1:0] RST_LAG_MAX    = 16'd65535;
    localparam logic [CFG_W-1:0] RST_JUMP_LIMIT = 16'd64;
    localparam logic [CFG_W-1:0] RST_DRIFT_MIN  = 16'd0;
    localparam logic [CFG_W-1:0] RST_DRIFT_GAIN = 16'd32768;
    localparam logic [CFG_W-1:0] RST_RATIO_GAIN = 16'd3277;
    localparam logic [CFG_W-1:0] RST_SPEECH_THR = 16'd16384;
    localparam logic [CFG_W-1:0] RST_PERIOD     = 16'd100;

    // per-source phase
    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_PROC      = 2'd1,
        PH_SPEECH    = 2'd2,
        PH_NONSPEECH = 2'd3
    } t_phase;

    // reported category
    typedef enum logic [CAT_W-1:0] {
        CAT_PROC      = 2'd0,
        CAT_SPEECH    = 2'd1,
        CAT_NONSPEECH = 2'd2
    } t_category;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC1,
        ST_CALC2,
        ST_WRITE
    } t_ctrl_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic step1;
        logic step2;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic emits;
        logic out_busy;
    } t_dp_status;

endpackage
`default_nettype wire

### src/ptsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptsc_ctrl
// Sequencer: captures a word, steps the datapath twice, then commits.
// ----------------------------------------------------------------------------
module ptsc_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire ptsc_pkg::t_dp_status i_status,
    output ptsc_pkg::t_dp_cmd        o_cmd
);
    import ptsc_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CALC1;
                end
            end
            ST_CALC1: n_state = ST_CALC2;
            ST_CALC2: n_state = ST_WRITE;
            ST_WRITE: begin
                if (!(i_status.emits && i_status.out_busy)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_CALC1: o_cmd.step1 = 1'b1;
            ST_CALC2: o_cmd.step2 = 1'b1;
            ST_WRITE: o_cmd.commit = !(i_status.emits && i_status.out_busy);
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

### src/ptsc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptsc_dp
// Datapath: configuration registers, per-source state, drift and voicing
// ratio arithmetic, and the output register.
// ----------------------------------------------------------------------------
module ptsc_dp #(
    parameter int NUM_SOURCES = ptsc_pkg::NUM_SOURCES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ptsc_pkg::t_dp_cmd               i_cmd,
    output ptsc_pkg::t_dp_status                 o_status,
    input  wire logic                            i_cfg_valid,
    input  wire logic [ptsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ptsc_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic [ptsc_pkg::SRC_W-1:0]      i_source_index,
    input  wire logic                            i_track_active,
    input  wire logic [ptsc_pkg::LAG_W-1:0]      i_pitch_lag,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [ptsc_pkg::SRC_W-1:0]           o_result_source,
    output logic [ptsc_pkg::CAT_W-1:0]           o_category
);
    import ptsc_pkg::*;

    // only indexes the source field can reach need storage
    localparam int DEPTH = (NUM_SOURCES < (1 << SRC_W)) ? NUM_SOURCES : (1 << SRC_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [SRC_W:0] DEPTH_V = (SRC_W + 1)'(DEPTH);

    function automatic logic [16:0] mag17(input logic signed [16:0] v);
        logic [16:0] m;
        m = v[16] ? 17'(-v) : 17'(v);
        return m;
    endfunction

    // configuration registers
    logic [CFG_W-1:0] r_lag_min, r_lag_max, r_jump_limit, r_drift_min;
    logic [CFG_W-1:0] r_drift_gain, r_ratio_gain, r_speech_thr, r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag_min    <= RST_LAG_MIN;
            r_lag_max    <= RST_LAG_MAX;
            r_jump_limit <= RST_JUMP_LIMIT;
            r_drift_min  <= RST_DRIFT_MIN;
            r_drift_gain <= RST_DRIFT_GAIN;
            r_ratio_gain <= RST_RATIO_GAIN;
            r_speech_thr <= RST_SPEECH_THR;
            r_period     <= RST_PERIOD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LAG_MIN:    r_lag_min    <= i_cfg_data;
                CFG_LAG_MAX:    r_lag_max    <= i_cfg_data;
                CFG_JUMP_LIMIT: r_jump_limit <= i_cfg_data;
                CFG_DRIFT_MIN:  r_drift_min  <= i_cfg_data;
                CFG_DRIFT_GAIN: r_drift_gain <= i_cfg_data;
                CFG_RATIO_GAIN: r_ratio_gain <= i_cfg_data;
                CFG_SPEECH_THR: r_speech_thr <= i_cfg_data;
                CFG_PERIOD:     r_period     <= i_cfg_data;
                default:        r_period     <= r_period;
            endcase
        end
    end

    // captured input word
    logic [SRC_W-1:0] r_src;
    logic             r_active;
    logic [LAG_W-1:0] r_lag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_src    <= i_source_index;
            r_active <= i_track_active;
            r_lag    <= i_pitch_lag;
        end
    end

    // per-source state
    t_phase              r_phase      [DEPTH];
    logic [15:0]         r_frames     [DEPTH];
    logic [15:0]         r_last_lag   [DEPTH];
    logic signed [16:0]  r_last_jump  [DEPTH];
    logic signed [16:0]  r_last_drift [DEPTH];
    logic [15:0]         r_ratio      [DEPTH];

    logic [IDX_W-1:0] idx;
    logic             in_range;
    assign idx      = r_src[IDX_W-1:0];
    assign in_range = ({1'b0, r_src} < DEPTH_V);

    // current entry
    t_phase             e_phase;
    logic [15:0]        e_frames;
    logic [15:0]        e_last_lag;
    logic signed [16:0] e_last_jump;
    logic signed [16:0] e_last_drift;
    logic [15:0]        e_ratio;

    assign e_phase      = r_phase[idx];
    assign e_frames     = r_frames[idx];
    assign e_last_lag   = r_last_lag[idx];
    assign e_last_jump  = r_last_jump[idx];
    assign e_last_drift = r_last_drift[idx];
    assign e_ratio      = r_ratio[idx];

    // step one: lag jump and drift blend product
    logic signed [16:0] jump;
    logic signed [17:0] jump_diff;
    logic               now_small;
    logic               prev_small;

    assign jump       = $signed({1'b0, r_lag}) - $signed({1'b0, e_last_lag});
    assign jump_diff  = 18'(jump) - 18'(e_last_drift);
    assign now_small  = mag17(jump) < {1'b0, r_jump_limit};
    assign prev_small = mag17(e_last_jump) < {1'b0, r_jump_limit};

    logic signed [16:0] r_jump;
    logic               r_now_small;
    logic               r_both_small;
    logic signed [34:0] r_drift_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step1) begin
            r_jump       <= jump;
            r_now_small  <= now_small;
            r_both_small <= now_small && prev_small;
            r_drift_prod <= $signed({1'b0, r_drift_gain}) * jump_diff;
        end
    end

    // step two: smoothed drift, voicing, ratio blend product
    logic signed [35:0] drift_acc;
    logic signed [16:0] drift;
    logic               voiced;
    logic signed [17:0] ratio_diff;

    assign drift_acc = $signed({{3{e_last_drift[16]}}, e_last_drift, 16'b0})
                     + 36'(r_drift_prod) + 36'sd32768;

    always_comb begin
        if (r_both_small) begin
            drift = drift_acc[32:16];
        end else if (r_now_small) begin
            drift = r_jump;
        end else begin
            drift = '0;
        end
    end

    assign voiced = (r_lag >= r_lag_min) && (r_lag <= r_lag_max)
                 && (mag17(drift) > {1'b0, r_drift_min});
    assign ratio_diff = $signed({1'b0, voiced, 16'b0}) - $signed({2'b0, e_ratio});

    logic signed [16:0] r_drift;
    logic signed [34:0] r_ratio_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step2) begin
            r_drift      <= drift;
            r_ratio_prod <= $signed({1'b0, r_ratio_gain}) * ratio_diff;
        end
    end

    // commit: ratio rounding with saturation
    logic signed [35:0] ratio_acc;
    logic [15:0]        new_ratio;

    assign ratio_acc = $signed({4'b0, e_ratio, 16'b0}) + 36'(r_ratio_prod) + 36'sd32768;
    assign new_ratio = ratio_acc[32] ? 16'hFFFF : ratio_acc[31:16];

    // commit: phase update
    t_phase n_phase;
    logic   counting;
    logic   track;

    always_comb begin
        n_phase  = (e_phase == PH_IDLE) ? PH_PROC : e_phase;
        counting = 1'b0;
        track    = 1'b0;
        if (n_phase == PH_PROC) begin
            if (e_frames < r_period) begin
                counting = 1'b1;
                track    = (r_lag != '0);
            end else begin
                n_phase = (e_ratio > r_speech_thr) ? PH_SPEECH : PH_NONSPEECH;
            end
        end
    end

    function automatic t_category phase_to_cat(input t_phase p);
        t_category c;
        case (p)
            PH_SPEECH:    c = CAT_SPEECH;
            PH_NONSPEECH: c = CAT_NONSPEECH;
            default:      c = CAT_PROC;
        endcase
        return c;
    endfunction

    // state write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_phase[i]      <= PH_IDLE;
                r_frames[i]     <= '0;
                r_last_lag[i]   <= '0;
                r_last_jump[i]  <= '0;
                r_last_drift[i] <= '0;
                r_ratio[i]      <= '0;
            end
        end else if (i_cmd.commit && in_range) begin
            if (!r_active) begin
                r_phase[idx]      <= PH_IDLE;
                r_frames[idx]     <= '0;
                r_last_lag[idx]   <= '0;
                r_last_jump[idx]  <= '0;
                r_last_drift[idx] <= '0;
                r_ratio[idx]      <= '0;
            end else begin
                r_phase[idx] <= n_phase;
                if (counting) begin
                    r_frames[idx] <= e_frames + 16'd1;
                end
                if (track) begin
                    r_last_lag[idx]   <= r_lag;
                    r_last_jump[idx]  <= r_jump;
                    r_last_drift[idx] <= r_drift;
                    r_ratio[idx]      <= new_ratio;
                end
            end
        end
    end

    // output register
    logic                  r_out_valid;
    logic [SRC_W-1:0]      r_out_src;
    t_category             r_out_cat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && r_active && in_range) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_active && in_range) begin
            r_out_src <= r_src;
            r_out_cat <= phase_to_cat(n_phase);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_source = r_out_src;
    assign o_category      = r_out_cat;

    // status to controller
    assign o_status.emits    = r_active && in_range;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

endmodule
`default_nettype wire

### src/pitch_track_speech_classifier_core.sv
// A result word is registered after the capture, two arithmetic steps and
// write back of its input word. A new input word is taken only after write
// back of the last one, as all of these share the per-source state.
// A full output register stalls write back of a word that yields a result until the held word is taken.
// Reset is synchronous, active low: restores register defaults and clears
// the state of every source.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pitch_track_speech_classifier_core
// Classifies each live sound source as speech or non-speech from its
// pitch track over a period of frames.
// ----------------------------------------------------------------------------
module pitch_track_speech_classifier_core #(
    parameter int NUM_SOURCES = ptsc_pkg::NUM_SOURCES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ptsc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ptsc_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [ptsc_pkg::SRC_W-1:0]      i_source_index,
    input  wire logic                            i_track_active,
    input  wire logic [ptsc_pkg::LAG_W-1:0]      i_pitch_lag,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [ptsc_pkg::SRC_W-1:0]           o_result_source,
    output logic [ptsc_pkg::CAT_W-1:0]           o_category
);
    import ptsc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    ptsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    ptsc_dp #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_source_index  (i_source_index),
        .i_track_active  (i_track_active),
        .i_pitch_lag     (i_pitch_lag),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_source (o_result_source),
        .o_category      (o_category)
    );

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pitch track speech classifier core. Frame
// reports from a mix of hand-picked cases and random pitch tracks go in
// through a bursty driver, a stalling monitor checks each category word
// against a per-source behavioral predictor, and the registers are
// reprogrammed between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import ptsc_pkg::*;

    localparam int NUM_SRC       = NUM_SOURCES_DEF;
    localparam int RAND_PHASES   = 8;
    localparam int FRAMES_PER_PH = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic             active;
        logic [LAG_W-1:0] lag;
    } t_frame_report;

    typedef struct packed {
        logic [SRC_W-1:0] src;
        t_category        cat;
    } t_verdict;

    // clock, reset and block inputs, all known from time zero
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_LAG_MIN;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic [SRC_W-1:0]     in_src      = '0;
    logic                 in_active   = 1'b0;
    logic [LAG_W-1:0]     in_lag      = '0;
    logic                 out_ready   = 1'b0;
    logic                 cfg_ready;
    logic                 in_ready;
    logic                 out_valid;
    logic [SRC_W-1:0]     out_src;
    logic [CAT_W-1:0]     out_cat;

    // predictor copy of the registers and per-source state
    int     cfg_shadow  [8];
    t_phase src_phase   [NUM_SRC];
    int     frames_seen [NUM_SRC];
    int     prev_lag    [NUM_SRC];
    int     prev_jump   [NUM_SRC];
    int     prev_drift  [NUM_SRC];
    int     ratio       [NUM_SRC];

    // random pitch track generator state
    int track_lag [NUM_SRC];
    int track_dir [NUM_SRC];

    t_frame_report frame_q   [$];
    t_verdict      verdict_q [$];
    int frames_queued = 0;
    int frames_taken  = 0;
    int errors        = 0;
    int cycles        = 0;
    int gap_left      = 0;
    int burst_left    = 0;
    int stall_left    = 0;
    int run_left      = 0;

    pitch_track_speech_classifier_core #(
        .NUM_SOURCES(NUM_SRC)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_source_index (in_src),
        .i_track_active (in_active),
        .i_pitch_lag    (in_lag),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_result_source(out_src),
        .o_category     (out_cat)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run time guard
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int abs_int(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // lag jump, smoothed drift, voicing decision and ratio update
    function automatic void follow_pitch(input int s, input int lag);
        int jump;
        int drift;
        int jl;
        int g;
        int rg;
        bit voiced;
        longint x;
        longint acc;
        jl   = cfg_shadow[CFG_JUMP_LIMIT];
        g    = cfg_shadow[CFG_DRIFT_GAIN];
        rg   = cfg_shadow[CFG_RATIO_GAIN];
        jump = lag - prev_lag[s];
        if (abs_int(jump) < jl && abs_int(prev_jump[s]) < jl) begin
            x = longint'(65536 - g) * prev_drift[s] + longint'(g) * jump;
            drift = int'((x + 32768) >>> 16);
        end else if (abs_int(jump) < jl) begin
            drift = jump;
        end else begin
            drift = 0;
        end
        voiced = lag >= cfg_shadow[CFG_LAG_MIN] && lag <= cfg_shadow[CFG_LAG_MAX]
                 && abs_int(drift) > cfg_shadow[CFG_DRIFT_MIN];
        acc = longint'(65536 - rg) * ratio[s] + 32768;
        if (voiced)
            acc += longint'(rg) << 16;
        acc = acc >> 16;
        ratio[s]      = (acc > 65535) ? 65535 : int'(acc);
        prev_lag[s]   = lag;
        prev_jump[s]  = jump;
        prev_drift[s] = drift;
    endfunction

    // advance one source on an accepted frame and queue its category word if the frame is live
    function automatic void classify_frame(input t_frame_report f);
        int s;
        t_verdict v;
        s = int'(f.src);
        if (!f.active) begin
            src_phase[s]   = PH_IDLE;
            frames_seen[s] = 0;
            prev_lag[s]    = 0;
            prev_jump[s]   = 0;
            prev_drift[s]  = 0;
            ratio[s]       = 0;
            return;
        end
        if (src_phase[s] == PH_IDLE)
            src_phase[s] = PH_PROC;
        if (src_phase[s] == PH_PROC) begin
            if (frames_seen[s] < cfg_shadow[CFG_PERIOD]) begin
                frames_seen[s]++;
                if (f.lag != 0)
                    follow_pitch(s, int'(f.lag));
            end else begin
                src_phase[s] = (ratio[s] > cfg_shadow[CFG_SPEECH_THR]) ?
                               PH_SPEECH : PH_NONSPEECH;
            end
        end
        v.src = f.src;
        case (src_phase[s])
            PH_SPEECH:    v.cat = CAT_SPEECH;
            PH_NONSPEECH: v.cat = CAT_NONSPEECH;
            default:      v.cat = CAT_PROC;
        endcase
        verdict_q.push_back(v);
    endfunction

    // mostly smooth drifting pitch tracks, the rest noise, no-peak and drop-outs
    function automatic t_frame_report make_frame();
        t_frame_report f;
        int s;
        int pick;
        int jl;
        int step;
        int lo;
        int hi;
        s    = $urandom_range(0, NUM_SRC - 1);
        jl   = cfg_shadow[CFG_JUMP_LIMIT];
        pick = $urandom_range(0, 99);
        f.src    = SRC_W'(s);
        f.active = 1'b1;
        f.lag    = '0;
        if (pick < 7) begin
            f.active = 1'b0;
            f.lag    = LAG_W'($urandom);
        end else if (pick < 15) begin
            f.lag = '0;
        end else if (pick < 25) begin
            f.lag = LAG_W'($urandom);
        end else begin
            if ($urandom_range(0, 7) == 0)
                track_dir[s] = -track_dir[s];
            step = (jl > 1) ? $urandom_range(jl / 4, jl - 1) : $urandom_range(0, 2);
            track_lag[s] += track_dir[s] * step;
            if (track_lag[s] < 1 || track_lag[s] > 65535 || $urandom_range(0, 30) == 0)
            begin
                lo = (cfg_shadow[CFG_LAG_MIN] < 1) ? 1 : cfg_shadow[CFG_LAG_MIN];
                hi = (cfg_shadow[CFG_LAG_MAX] < 1) ? 1 : cfg_shadow[CFG_LAG_MAX];
                track_lag[s] = $urandom_range(hi, lo);
            end
            f.lag = LAG_W'(track_lag[s]);
        end
        return f;
    endfunction

    // register sets, lag_min first and frame_period last
    function automatic logic [127:0] setting_row(input int p);
        case (p)
            0: return {16'd0, 16'd65535, 16'd64, 16'd0,
                       16'd32768, 16'd3277, 16'd16384, 16'd0};
            1: return {16'd0, 16'd65535, 16'd64, 16'd0,
                       16'd32768, 16'd65535, 16'd0, 16'd3};
            2: return {16'd100, 16'd20000, 16'd64, 16'd0,
                       16'd32768, 16'd3277, 16'd16384, 16'd8};
            3: return {16'd0, 16'd65535, 16'd65535, 16'd0,
                       16'd0, 16'd65535, 16'd0, 16'd5};
            4: return {16'd65535, 16'd65535, 16'd1, 16'd65535,
                       16'd65535, 16'd1, 16'd65535, 16'd1};
            5: return {16'd1000, 16'd60000, 16'd2000, 16'd10,
                       16'd20000, 16'd30000, 16'd30000, 16'd12};
            6: return {16'd0, 16'd0, 16'd0, 16'd0,
                       16'd1, 16'd0, 16'd1, 16'd4};
            7: return {16'd500, 16'd40000, 16'd300, 16'd5,
                       16'd50000, 16'd8000, 16'd10000, 16'd20};
            8: return {16'd0, 16'd65535, 16'd128, 16'd2,
                       16'd40000, 16'd12000, 16'd20000, 16'd65535};
            default: return {16'd2000, 16'd30000, 16'd64, 16'd0,
                             16'd32768, 16'd3277, 16'd16384, 16'd16};
        endcase
    endfunction

    task automatic push_frame(input int s, input bit act, input int lag);
        t_frame_report f;
        f.src    = SRC_W'(s);
        f.active = act;
        f.lag    = LAG_W'(lag);
        frame_q.push_back(f);
        frames_queued++;
    endtask

    // write all registers back to back, valid held high across the words
    task automatic program_regs(input logic [127:0] row);
        int r;
        for (r = int'(CFG_LAG_MIN); r <= int'(CFG_PERIOD); r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= row[127 - 16 * r -: 16];
            do @(posedge clk); while (!cfg_ready);
            cfg_shadow[r] = int'(row[127 - 16 * r -: 16]);
        end
        cfg_valid <= 1'b0;
    endtask

    // wait for every frame taken and every word returned, then let the core settle
    task automatic drain();
        while (frames_taken != frames_queued || verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // input driver: bursts of frames with random gaps
    always @(posedge clk) begin : feeder
        t_frame_report got;
        t_frame_report nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                got.src    = in_src;
                got.active = in_active;
                got.lag    = in_lag;
                classify_frame(got);
                frames_taken++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (frame_q.size() > 0) begin
                    nxt = frame_q.pop_front();
                    in_src    <= nxt.src;
                    in_active <= nxt.active;
                    in_lag    <= nxt.lag;
                    in_valid  <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: checks each word, ready follows runs and stalls
    always @(posedge clk) begin : out_monitor
        t_verdict want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected word: result_source %0d category %0d",
                           out_src, out_cat);
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (out_src !== want.src) begin
                        $error("result_source mismatch: expected %0d, actual %0d",
                               want.src, out_src);
                        errors++;
                    end
                    if (out_cat !== want.cat) begin
                        $error("category mismatch: expected %0d, actual %0d",
                               want.cat, out_cat);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left   = $urandom_range(0, 30);
                    stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // phases: directed cases, then random tracks under several register sets
    initial begin : sequencer
        int p;
        int n;
        int s;
        for (s = 0; s < NUM_SRC; s++) begin
            src_phase[s]   = PH_IDLE;
            frames_seen[s] = 0;
            prev_lag[s]    = 0;
            prev_jump[s]   = 0;
            prev_drift[s]  = 0;
            ratio[s]       = 0;
            track_lag[s]   = 1000 + 500 * s;
            track_dir[s]   = 1;
        end
        cfg_shadow[CFG_LAG_MIN]    = int'(RST_LAG_MIN);
        cfg_shadow[CFG_LAG_MAX]    = int'(RST_LAG_MAX);
        cfg_shadow[CFG_JUMP_LIMIT] = int'(RST_JUMP_LIMIT);
        cfg_shadow[CFG_DRIFT_MIN]  = int'(RST_DRIFT_MIN);
        cfg_shadow[CFG_DRIFT_GAIN] = int'(RST_DRIFT_GAIN);
        cfg_shadow[CFG_RATIO_GAIN] = int'(RST_RATIO_GAIN);
        cfg_shadow[CFG_SPEECH_THR] = int'(RST_SPEECH_THR);
        cfg_shadow[CFG_PERIOD]     = int'(RST_PERIOD);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: no-peak frame, lag extremes, drop-outs, big jump
        push_frame(0, 1'b1, 0);
        push_frame(0, 1'b1, 65535);
        push_frame(0, 1'b1, 65530);
        push_frame(0, 1'b1, 65520);
        push_frame(0, 1'b1, 0);
        push_frame(0, 1'b0, 0);
        push_frame(7, 1'b1, 1);
        push_frame(7, 1'b1, 30);
        push_frame(7, 1'b0, 65535);
        push_frame(5, 1'b0, 16'h5555);
        push_frame(2, 1'b1, 16'haaaa);
        push_frame(2, 1'b1, 16'h5555);
        drain();

        // zero period decides on the first live frame, then stays latched
        program_regs(setting_row(0));
        push_frame(1, 1'b1, 100);
        push_frame(1, 1'b1, 200);
        push_frame(1, 1'b0, 0);
        push_frame(1, 1'b1, 300);
        drain();

        // short period with a smooth track reaches speech, then latches
        program_regs(setting_row(1));
        push_frame(4, 1'b1, 1000);
        push_frame(4, 1'b1, 1010);
        push_frame(4, 1'b1, 1020);
        push_frame(4, 1'b1, 1030);
        push_frame(4, 1'b1, 5000);
        push_frame(4, 1'b0, 0);
        drain();

        // random phases
        for (p = 2; p < 2 + RAND_PHASES; p++) begin
            program_regs(setting_row(p));
            for (n = 0; n < FRAMES_PER_PH; n++) begin
                frame_q.push_back(make_frame());
                frames_queued++;
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
src/ptsc_pkg.sv
src/ptsc_ctrl.sv
src/ptsc_dp.sv
src/pitch_track_speech_classifier_core.sv
verif/tb_top.sv
